### rtl/giou_pkg.sv
// shared types, codes and constants of the greedy iou track associator
package giou_pkg;

  localparam int MAX_TRACKS_DEF = 16;
  localparam int MAX_DETS_DEF   = 16;
  localparam int NUM_CORNERS    = 4;

  localparam int TIDX_W  = 5;
  localparam int DIDX_W  = 6;
  localparam int TCNT_W  = 5;
  localparam int DCNT_W  = 7;
  localparam int PADDR_W = 4;

  localparam logic [1:0] KIND_BOX    = 2'd0;
  localparam logic [1:0] KIND_CORNER = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  localparam logic [1:0] PART_BOX = 2'd0;
  localparam logic [1:0] PART_C01 = 2'd1;
  localparam logic [1:0] PART_C23 = 2'd2;

  localparam logic [1:0] REG_IOU    = 2'd0;
  localparam logic [1:0] REG_ALPHA  = 2'd1;
  localparam logic [1:0] REG_MISSED = 2'd2;

  localparam logic [8:0] IOU_RESET    = 9'd77;
  localparam logic [8:0] ALPHA_RESET  = 9'd128;
  localparam logic [7:0] MISSED_RESET = 8'd5;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic [14:0]        box_w;
    logic [14:0]        box_h;
    logic [15:0]        det_score;
    logic [1:0]         corner_index;
    logic signed [15:0] corner_x;
    logic signed [15:0] corner_y;
  } det_item_t;

  typedef struct packed {
    logic [31:0]        track_id;
    logic [1:0]         part;
    logic signed [15:0] val_a;
    logic signed [15:0] val_b;
    logic signed [15:0] val_c;
    logic signed [15:0] val_d;
    logic [15:0]        track_score;
    logic [15:0]        track_age;
    logic [7:0]         track_missed;
    logic               last;
  } trk_item_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [14:0] w;
    logic [14:0] h;
  } box_t;

  typedef logic [NUM_CORNERS-1:0][1:0][15:0] corners_t;

  typedef struct packed {
    box_t        box;
    logic [15:0] score;
    logic [29:0] area;
    corners_t    corners;
  } det_rec_t;

  typedef struct packed {
    logic [31:0] id;
    box_t        box;
    corners_t    corners;
    logic [15:0] score;
    logic [15:0] age;
    logic [7:0]  missed;
  } trk_rec_t;

  typedef struct packed {
    logic [8:0] iou_threshold;
    logic [8:0] blend_alpha;
    logic [7:0] missed_limit;
  } cfg_t;

  typedef struct packed {
    logic              load;
    logic              flush;
    logic              best_init;
    logic              trk_rd;
    logic              trk_latch;
    logic              det_rd;
    logic              det_from_pair;
    logic              ovl;
    logic              mul;
    logic              uni;
    logic              prod;
    logic              dec;
    logic              pair;
    logic              upd_wr;
    logic              set_cnt;
    logic              app;
    logic              frame_done;
    logic              emit;
    logic              last;
    logic [1:0]        part;
    logic [TIDX_W-1:0] trk_idx;
    logic [DIDX_W-1:0] det_idx;
    logic [TIDX_W-1:0] wr_idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [TCNT_W-1:0] trk_cnt;
    logic [DCNT_W-1:0] det_cnt;
    logic              trk_matched;
    logic              det_used;
    logic              found;
    logic              keep;
    logic              trk_full;
    logic              out_free;
  } dp_status_t;

endpackage

### rtl/greedy_iou_track_associator.sv
// top level: detection load one item per cycle; end of frame runs greedy pairing rounds over
// free track-detection pairs (one shared iou compare sequence), then track updates, new
// tracks and emission of each track as 3 result items
// the next frame's items are accepted while the final result item still waits
// synchronous reset clears counts, identifier counter and registers to defaults; no clearing pass
module greedy_iou_track_associator #(
  parameter int MAX_TRACKS = giou_pkg::MAX_TRACKS_DEF,
  parameter int MAX_DETS   = giou_pkg::MAX_DETS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         det_valid,
  output logic                         det_ready,
  input  giou_pkg::det_item_t          det_item,
  output logic                         trk_valid,
  input  logic                         trk_ready,
  output giou_pkg::trk_item_t          trk_item,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [giou_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import giou_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t st;

  giou_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  giou_ctrl #(
    .MAX_TRACKS (MAX_TRACKS),
    .MAX_DETS   (MAX_DETS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .det_valid (det_valid),
    .det_kind  (det_item.kind),
    .det_ready (det_ready),
    .st        (st),
    .cmd       (cmd)
  );

  giou_dp #(
    .MAX_TRACKS (MAX_TRACKS),
    .MAX_DETS   (MAX_DETS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .det_item  (det_item),
    .st        (st),
    .trk_valid (trk_valid),
    .trk_ready (trk_ready),
    .trk_item  (trk_item)
  );

endmodule

### rtl/giou_cfg.sv
// apb register file for threshold, blend weight and miss limit
module giou_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [giou_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output giou_pkg::cfg_t               cfg
);
  import giou_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.iou_threshold <= IOU_RESET;
      cfg.blend_alpha   <= ALPHA_RESET;
      cfg.missed_limit  <= MISSED_RESET;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_IOU:    cfg.iou_threshold <= pwdata[8:0];
        REG_ALPHA:  cfg.blend_alpha   <= pwdata[8:0];
        REG_MISSED: cfg.missed_limit  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_IOU:    prdata = {23'd0, cfg.iou_threshold};
      REG_ALPHA:  prdata = {23'd0, cfg.blend_alpha};
      REG_MISSED: prdata = {24'd0, cfg.missed_limit};
      default:    prdata = '0;
    endcase
  end

endmodule

### rtl/giou_dp.sv
// datapath: detection and track stores, iou compare, blending and output register
module giou_dp #(
  parameter int MAX_TRACKS = giou_pkg::MAX_TRACKS_DEF,
  parameter int MAX_DETS   = giou_pkg::MAX_DETS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  giou_pkg::cfg_t         cfg,
  input  giou_pkg::ctrl_cmd_t    cmd,
  input  giou_pkg::det_item_t    det_item,
  output giou_pkg::dp_status_t   st,
  output logic                   trk_valid,
  input  logic                   trk_ready,
  output giou_pkg::trk_item_t    trk_item
);
  import giou_pkg::*;

  localparam int TIW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int DIW = (MAX_DETS > 1) ? $clog2(MAX_DETS) : 1;
  localparam int TCW = $clog2(MAX_TRACKS + 1);
  localparam int DCW = $clog2(MAX_DETS + 1);

  function automatic logic [15:0] blend16(input logic [15:0] d, input logic [15:0] t,
                                          input logic [8:0] a);
    logic signed [16:0] diff;
    logic signed [26:0] prod;
    logic signed [18:0] sum;
    diff = $signed({d[15], d}) - $signed({t[15], t});
    prod = $signed({1'b0, a}) * diff;
    sum  = $signed({{3{t[15]}}, t}) + $signed(prod[26:8]);
    return sum[15:0];
  endfunction

  function automatic logic [14:0] overlap(input logic [15:0] a0, input logic [14:0] aw,
                                          input logic [15:0] b0, input logic [14:0] bw);
    logic signed [16:0] ea, eb, lo, hi, df;
    ea = $signed({a0[15], a0}) + $signed({2'b00, aw});
    eb = $signed({b0[15], b0}) + $signed({2'b00, bw});
    lo = ($signed(a0) > $signed(b0)) ? $signed({a0[15], a0}) : $signed({b0[15], b0});
    hi = (ea < eb) ? ea : eb;
    df = hi - lo;
    return (hi > lo) ? df[14:0] : 15'd0;
  endfunction

  det_rec_t det_mem [MAX_DETS];
  trk_rec_t trk_mem [MAX_TRACKS];
  det_rec_t det_q, pend, new_det, det_wd;
  trk_rec_t trk_q, upd, trk_wd;

  logic [TCW-1:0] trk_cnt;
  logic [DCW-1:0] det_cnt, det_last;
  logic           latest_ok, pend_valid, room, det_we, trk_we, is_box;
  logic [31:0]    next_ident;
  logic           trk_match [MAX_TRACKS];
  logic [DIW-1:0] pair_det  [MAX_TRACKS];
  logic           det_used  [MAX_DETS];
  logic [TIW-1:0] ti, wi, trk_wa, bi;
  logic [DIW-1:0] di, det_ra, det_wa, bj;
  logic [29:0]    t_area, inter, bn;
  logic [14:0]    iw, ih;
  logic [30:0]    uni, bd, uni_sum;
  logic [60:0]    p1, p2;
  logic           found, keep, out_valid;
  logic [8:0]     a_eff;
  trk_item_t      emit_item;

  assign ti       = cmd.trk_idx[TIW-1:0];
  assign di       = cmd.det_idx[DIW-1:0];
  assign wi       = cmd.wr_idx[TIW-1:0];
  assign det_ra   = cmd.det_from_pair ? pair_det[ti] : di;
  assign det_last = det_cnt - DCW'(1);
  assign det_wa   = det_last[DIW-1:0];
  assign room     = det_cnt < DCW'(MAX_DETS);
  assign is_box   = cmd.load && (det_item.kind == KIND_BOX);
  assign det_we   = pend_valid && ((is_box && room) || cmd.flush);
  assign det_wd   = pend;
  assign a_eff    = (cfg.blend_alpha > 9'd256) ? 9'd256 : cfg.blend_alpha;
  assign uni_sum  = {1'b0, t_area} + {1'b0, det_q.area} - {1'b0, inter};

  always_comb begin
    new_det.box.x   = det_item.box_x;
    new_det.box.y   = det_item.box_y;
    new_det.box.w   = det_item.box_w;
    new_det.box.h   = det_item.box_h;
    new_det.score   = det_item.det_score;
    new_det.area    = det_item.box_w * det_item.box_h;
    new_det.corners = '0;
  end

  // matched or missed track update
  always_comb begin
    logic [15:0] bw, bh;
    bw = blend16({1'b0, det_q.box.w}, {1'b0, trk_q.box.w}, a_eff);
    bh = blend16({1'b0, det_q.box.h}, {1'b0, trk_q.box.h}, a_eff);
    upd     = trk_q;
    upd.age = (trk_q.age == 16'hFFFF) ? trk_q.age : trk_q.age + 16'd1;
    if (trk_match[ti]) begin
      upd.missed = '0;
      upd.score  = det_q.score;
      upd.box.x  = blend16(det_q.box.x, trk_q.box.x, a_eff);
      upd.box.y  = blend16(det_q.box.y, trk_q.box.y, a_eff);
      upd.box.w  = bw[14:0];
      upd.box.h  = bh[14:0];
      for (int k = 0; k < NUM_CORNERS; k++) begin
        for (int c = 0; c < 2; c++) begin
          upd.corners[k][c] = blend16(det_q.corners[k][c], trk_q.corners[k][c], a_eff);
        end
      end
    end else if (trk_q.missed != 8'hFF) begin
      upd.missed = trk_q.missed + 8'd1;
    end
    keep = upd.missed <= cfg.missed_limit;
  end

  always_comb begin
    if (cmd.app) begin
      trk_wd.id      = next_ident;
      trk_wd.box     = det_q.box;
      trk_wd.corners = det_q.corners;
      trk_wd.score   = det_q.score;
      trk_wd.age     = 16'd1;
      trk_wd.missed  = '0;
      trk_wa         = trk_cnt[TIW-1:0];
    end else begin
      trk_wd = upd;
      trk_wa = wi;
    end
    trk_we = cmd.app || (cmd.upd_wr && keep);
  end

  always_ff @(posedge clk) begin
    if (det_we) det_mem[det_wa] <= det_wd;
    if (cmd.det_rd) det_q <= det_mem[det_ra];
    if (trk_we) trk_mem[trk_wa] <= trk_wd;
    if (cmd.trk_rd) trk_q <= trk_mem[ti];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trk_cnt    <= '0;
      det_cnt    <= '0;
      latest_ok  <= 1'b0;
      pend_valid <= 1'b0;
      next_ident <= '0;
      found      <= 1'b0;
      out_valid  <= 1'b0;
      for (int t = 0; t < MAX_TRACKS; t++) trk_match[t] <= 1'b0;
      for (int d = 0; d < MAX_DETS; d++) det_used[d] <= 1'b0;
    end else begin
      if (is_box) begin
        if (room) begin
          pend       <= new_det;
          pend_valid <= 1'b1;
          det_cnt    <= det_cnt + DCW'(1);
          latest_ok  <= 1'b1;
        end else begin
          latest_ok <= 1'b0;
        end
      end
      if (cmd.load && det_item.kind == KIND_CORNER && latest_ok) begin
        pend.corners[det_item.corner_index][0] <= det_item.corner_x;
        pend.corners[det_item.corner_index][1] <= det_item.corner_y;
      end
      if (cmd.flush) begin
        pend_valid <= 1'b0;
        for (int t = 0; t < MAX_TRACKS; t++) trk_match[t] <= 1'b0;
        for (int d = 0; d < MAX_DETS; d++) det_used[d] <= 1'b0;
      end
      if (cmd.best_init) begin
        bn    <= 30'(cfg.iou_threshold);
        bd    <= 31'd256;
        found <= 1'b0;
      end
      if (cmd.trk_latch) t_area <= trk_q.box.w * trk_q.box.h;
      if (cmd.ovl) begin
        iw <= overlap(trk_q.box.x, trk_q.box.w, det_q.box.x, det_q.box.w);
        ih <= overlap(trk_q.box.y, trk_q.box.h, det_q.box.y, det_q.box.h);
      end
      if (cmd.mul) inter <= iw * ih;
      if (cmd.uni) begin
        if (uni_sum == '0) begin
          uni   <= 31'd1;
          inter <= '0;
        end else begin
          uni <= uni_sum;
        end
      end
      if (cmd.prod) begin
        p1 <= inter * bd;
        p2 <= bn * uni;
      end
      if (cmd.dec && p1 > p2) begin
        bn    <= inter;
        bd    <= uni;
        bi    <= ti;
        bj    <= di;
        found <= 1'b1;
      end
      if (cmd.pair) begin
        trk_match[bi] <= 1'b1;
        pair_det[bi]  <= bj;
        det_used[bj]  <= 1'b1;
      end
      if (cmd.set_cnt) trk_cnt <= cmd.wr_idx[TCW-1:0];
      if (cmd.app) begin
        trk_cnt    <= trk_cnt + TCW'(1);
        next_ident <= next_ident + 32'd1;
      end
      if (cmd.frame_done) begin
        det_cnt   <= '0;
        latest_ok <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        trk_item  <= emit_item;
      end else if (trk_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    emit_item.track_id     = trk_q.id;
    emit_item.part         = cmd.part;
    emit_item.track_score  = trk_q.score;
    emit_item.track_age    = trk_q.age;
    emit_item.track_missed = trk_q.missed;
    emit_item.last         = cmd.last;
    case (cmd.part)
      PART_C01: begin
        emit_item.val_a = trk_q.corners[0][0];
        emit_item.val_b = trk_q.corners[0][1];
        emit_item.val_c = trk_q.corners[1][0];
        emit_item.val_d = trk_q.corners[1][1];
      end
      PART_C23: begin
        emit_item.val_a = trk_q.corners[2][0];
        emit_item.val_b = trk_q.corners[2][1];
        emit_item.val_c = trk_q.corners[3][0];
        emit_item.val_d = trk_q.corners[3][1];
      end
      default: begin
        emit_item.val_a = trk_q.box.x;
        emit_item.val_b = trk_q.box.y;
        emit_item.val_c = {1'b0, trk_q.box.w};
        emit_item.val_d = {1'b0, trk_q.box.h};
      end
    endcase
  end

  assign trk_valid      = out_valid;
  assign st.trk_cnt     = TCNT_W'(trk_cnt);
  assign st.det_cnt     = DCNT_W'(det_cnt);
  assign st.trk_matched = trk_match[ti];
  assign st.det_used    = det_used[di];
  assign st.found       = found;
  assign st.keep        = keep;
  assign st.trk_full    = trk_cnt == TCW'(MAX_TRACKS);
  assign st.out_free    = !out_valid || trk_ready;

endmodule

### rtl/giou_ctrl.sv
// controller: load, greedy pairing rounds, update, append and emit sequencing
module giou_ctrl #(
  parameter int MAX_TRACKS = giou_pkg::MAX_TRACKS_DEF,
  parameter int MAX_DETS   = giou_pkg::MAX_DETS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  det_valid,
  input  logic [1:0]            det_kind,
  output logic                  det_ready,
  input  giou_pkg::dp_status_t  st,
  output giou_pkg::ctrl_cmd_t   cmd
);
  import giou_pkg::*;

  localparam int TCW = $clog2(MAX_TRACKS + 1);
  localparam int DCW = $clog2(MAX_DETS + 1);

  localparam logic [4:0] S_LOAD   = 5'd0;
  localparam logic [4:0] S_FLUSH  = 5'd1;
  localparam logic [4:0] S_RSTART = 5'd2;
  localparam logic [4:0] S_TCHK   = 5'd3;
  localparam logic [4:0] S_TLOAD  = 5'd4;
  localparam logic [4:0] S_DCHK   = 5'd5;
  localparam logic [4:0] S_P1     = 5'd6;
  localparam logic [4:0] S_P2     = 5'd7;
  localparam logic [4:0] S_P3     = 5'd8;
  localparam logic [4:0] S_P4     = 5'd9;
  localparam logic [4:0] S_P5     = 5'd10;
  localparam logic [4:0] S_RDONE  = 5'd11;
  localparam logic [4:0] S_URD    = 5'd12;
  localparam logic [4:0] S_UWR    = 5'd13;
  localparam logic [4:0] S_ACHK   = 5'd14;
  localparam logic [4:0] S_AWR    = 5'd15;
  localparam logic [4:0] S_EBEGIN = 5'd16;
  localparam logic [4:0] S_ERD    = 5'd17;
  localparam logic [4:0] S_EOUT   = 5'd18;

  logic [4:0]     state, state_next;
  logic [TCW-1:0] i, i_next, w, w_next, tc;
  logic [DCW-1:0] j, j_next, dc;
  logic [1:0]     part, part_next;
  logic           last_trk;

  assign tc        = st.trk_cnt[TCW-1:0];
  assign dc        = st.det_cnt[DCW-1:0];
  assign det_ready = state == S_LOAD;
  assign last_trk  = (i + TCW'(1)) == tc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      i     <= '0;
      j     <= '0;
      w     <= '0;
      part  <= PART_BOX;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      w     <= w_next;
      part  <= part_next;
    end
  end

  always_comb begin
    state_next  = state;
    i_next      = i;
    j_next      = j;
    w_next      = w;
    part_next   = part;
    cmd         = '0;
    cmd.trk_idx = TIDX_W'(i);
    cmd.det_idx = DIDX_W'(j);
    cmd.wr_idx  = TIDX_W'(w);
    cmd.part    = part;
    unique case (state)
      S_LOAD: begin
        if (det_valid) begin
          cmd.load = 1'b1;
          if (det_kind == KIND_END) state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd.flush  = 1'b1;
        state_next = S_RSTART;
      end
      S_RSTART: begin
        cmd.best_init = 1'b1;
        i_next        = '0;
        state_next    = S_TCHK;
      end
      S_TCHK: begin
        if (i == tc) begin
          state_next = S_RDONE;
        end else if (st.trk_matched) begin
          i_next = i + TCW'(1);
        end else begin
          cmd.trk_rd = 1'b1;
          state_next = S_TLOAD;
        end
      end
      S_TLOAD: begin
        cmd.trk_latch = 1'b1;
        j_next        = '0;
        state_next    = S_DCHK;
      end
      S_DCHK: begin
        if (j == dc) begin
          i_next     = i + TCW'(1);
          state_next = S_TCHK;
        end else if (st.det_used) begin
          j_next = j + DCW'(1);
        end else begin
          cmd.det_rd = 1'b1;
          state_next = S_P1;
        end
      end
      S_P1: begin
        cmd.ovl    = 1'b1;
        state_next = S_P2;
      end
      S_P2: begin
        cmd.mul    = 1'b1;
        state_next = S_P3;
      end
      S_P3: begin
        cmd.uni    = 1'b1;
        state_next = S_P4;
      end
      S_P4: begin
        cmd.prod   = 1'b1;
        state_next = S_P5;
      end
      S_P5: begin
        cmd.dec    = 1'b1;
        j_next     = j + DCW'(1);
        state_next = S_DCHK;
      end
      S_RDONE: begin
        if (st.found) begin
          cmd.pair   = 1'b1;
          state_next = S_RSTART;
        end else begin
          i_next     = '0;
          w_next     = '0;
          state_next = S_URD;
        end
      end
      S_URD: begin
        if (i == tc) begin
          cmd.set_cnt = 1'b1;
          j_next      = '0;
          state_next  = S_ACHK;
        end else begin
          cmd.trk_rd        = 1'b1;
          cmd.det_rd        = 1'b1;
          cmd.det_from_pair = 1'b1;
          state_next        = S_UWR;
        end
      end
      S_UWR: begin
        cmd.upd_wr = 1'b1;
        if (st.keep) w_next = w + TCW'(1);
        i_next     = i + TCW'(1);
        state_next = S_URD;
      end
      S_ACHK: begin
        if (j == dc || st.trk_full) begin
          state_next = S_EBEGIN;
        end else if (st.det_used) begin
          j_next = j + DCW'(1);
        end else begin
          cmd.det_rd = 1'b1;
          state_next = S_AWR;
        end
      end
      S_AWR: begin
        cmd.app    = 1'b1;
        j_next     = j + DCW'(1);
        state_next = S_ACHK;
      end
      S_EBEGIN: begin
        cmd.frame_done = 1'b1;
        i_next         = '0;
        state_next     = (tc == '0) ? S_LOAD : S_ERD;
      end
      S_ERD: begin
        cmd.trk_rd = 1'b1;
        part_next  = PART_BOX;
        state_next = S_EOUT;
      end
      S_EOUT: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = (part == PART_C23) && last_trk;
          if (part == PART_C23) begin
            if (last_trk) begin
              state_next = S_LOAD;
            end else begin
              i_next     = i + TCW'(1);
              state_next = S_ERD;
            end
          end else begin
            part_next = part + 2'd1;
          end
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

endmodule

### test/testbench.sv
// self-checking testbench of the greedy iou track associator
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import giou_pkg::*;

  localparam int NTRK = 16;
  localparam int NDET = 16;
  localparam int IDLE_LIMIT = 200000;
  localparam int SETTLE = 4000;
  localparam int HOLD_LONG = 3000;

  typedef struct {
    logic [31:0] id;
    int box[4];
    int crn[4][2];
    int score;
    int age;
    int missed;
  } track_t;

  typedef struct {
    int box[4];
    int crn[4][2];
    int score;
  } det_t;

  logic clk = 0;
  logic rst = 1;
  logic det_valid = 0;
  logic det_ready;
  det_item_t det_item = '0;
  logic trk_valid;
  logic trk_ready = 0;
  trk_item_t trk_item;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  greedy_iou_track_associator dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state
  int thr_q8 = IOU_RESET, alpha_q8 = ALPHA_RESET, miss_lim = MISSED_RESET;
  track_t tracks[$];
  det_t dets[$];
  bit latest_ok;
  logic [31:0] ident_next;

  det_item_t pending_items[$];
  trk_item_t expected_tracks[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 0;
  bit hold_done = 0;
  int hold_left = 0;
  bit drain_req = 0;

  task automatic report(string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  task automatic enqueue_in(det_item_t it);
    pending_items = {pending_items, it};
  endtask

  task automatic add_expected(trk_item_t it);
    expected_tracks = {expected_tracks, it};
  endtask

  function automatic int blend_floor(int d, int t, int a);
    longint v;
    v = longint'(a) * d + longint'(256 - a) * t;
    if (v >= 0) return int'(v / 256);
    return int'(-((-v + 255) / 256));
  endfunction

  function automatic void overlap(int ta[4], int db[4], output longint i, output longint u);
    longint lo, hi, iw, ih;
    lo = ta[0] > db[0] ? ta[0] : db[0];
    hi = (longint'(ta[0]) + ta[2]) < (longint'(db[0]) + db[2]) ?
         longint'(ta[0]) + ta[2] : longint'(db[0]) + db[2];
    iw = hi > lo ? hi - lo : 0;
    lo = ta[1] > db[1] ? ta[1] : db[1];
    hi = (longint'(ta[1]) + ta[3]) < (longint'(db[1]) + db[3]) ?
         longint'(ta[1]) + ta[3] : longint'(db[1]) + db[3];
    ih = hi > lo ? hi - lo : 0;
    i = iw * ih;
    u = longint'(ta[2]) * ta[3] + longint'(db[2]) * db[3] - i;
    if (u <= 0) begin
      i = 0;
      u = 1;
    end
  endfunction

  function automatic trk_item_t make_out(track_t t, logic [1:0] p, int a, int b, int c, int d,
                                         bit lst);
    trk_item_t o;
    o.track_id = t.id;
    o.part = p;
    o.val_a = a[15:0];
    o.val_b = b[15:0];
    o.val_c = c[15:0];
    o.val_d = d[15:0];
    o.track_score = t.score[15:0];
    o.track_age = t.age[15:0];
    o.track_missed = t.missed[7:0];
    o.last = lst;
    return o;
  endfunction

  task automatic track_frame();
    longint inter[NTRK][NDET], uni[NTRK][NDET];
    int tp[NTRK], dp[NDET];
    longint bn, bd;
    int bi, bj, a, nt, nd, d;
    track_t kept[$];
    track_t nt_rec;
    nt = tracks.size();
    nd = dets.size();
    a = alpha_q8 > 256 ? 256 : alpha_q8;
    for (int i = 0; i < nt; i++) tp[i] = -1;
    for (int j = 0; j < nd; j++) dp[j] = -1;
    for (int i = 0; i < nt; i++)
      for (int j = 0; j < nd; j++) overlap(tracks[i].box, dets[j].box, inter[i][j], uni[i][j]);
    forever begin
      bn = thr_q8;
      bd = 256;
      bi = -1;
      bj = -1;
      for (int i = 0; i < nt; i++) begin
        if (tp[i] >= 0) continue;
        for (int j = 0; j < nd; j++) begin
          if (dp[j] >= 0) continue;
          if (inter[i][j] * bd > bn * uni[i][j]) begin
            bn = inter[i][j];
            bd = uni[i][j];
            bi = i;
            bj = j;
          end
        end
      end
      if (bi < 0) break;
      tp[bi] = bj;
      dp[bj] = bi;
    end
    for (int i = 0; i < nt; i++) begin
      if (tracks[i].age < 65535) tracks[i].age++;
      if (tp[i] >= 0) begin
        d = tp[i];
        tracks[i].missed = 0;
        tracks[i].score = dets[d].score;
        for (int k = 0; k < 4; k++)
          tracks[i].box[k] = blend_floor(dets[d].box[k], tracks[i].box[k], a);
        for (int k = 0; k < 4; k++)
          for (int e = 0; e < 2; e++)
            tracks[i].crn[k][e] = blend_floor(dets[d].crn[k][e], tracks[i].crn[k][e], a);
      end else if (tracks[i].missed < 255) begin
        tracks[i].missed++;
      end
      if (tracks[i].missed <= miss_lim) kept = {kept, tracks[i]};
    end
    tracks = kept;
    for (int j = 0; j < nd; j++) begin
      if (dp[j] >= 0 || tracks.size() >= NTRK) continue;
      nt_rec.id = ident_next;
      ident_next++;
      nt_rec.box = dets[j].box;
      nt_rec.crn = dets[j].crn;
      nt_rec.score = dets[j].score;
      nt_rec.age = 1;
      nt_rec.missed = 0;
      tracks = {tracks, nt_rec};
    end
    foreach (tracks[i]) begin
      add_expected(make_out(tracks[i], PART_BOX, tracks[i].box[0], tracks[i].box[1],
                            tracks[i].box[2], tracks[i].box[3], 0));
      add_expected(make_out(tracks[i], PART_C01, tracks[i].crn[0][0],
                            tracks[i].crn[0][1], tracks[i].crn[1][0],
                            tracks[i].crn[1][1], 0));
      add_expected(make_out(tracks[i], PART_C23, tracks[i].crn[2][0],
                            tracks[i].crn[2][1], tracks[i].crn[3][0],
                            tracks[i].crn[3][1], i == tracks.size() - 1));
    end
    dets.delete();
    latest_ok = 0;
  endtask

  task automatic predict_item(det_item_t it);
    det_t nd_rec;
    case (it.kind)
      KIND_BOX: begin
        if (dets.size() >= NDET) begin
          latest_ok = 0;
        end else begin
          nd_rec.box[0] = int'(it.box_x);
          nd_rec.box[1] = int'(it.box_y);
          nd_rec.box[2] = int'(it.box_w);
          nd_rec.box[3] = int'(it.box_h);
          nd_rec.score = int'(it.det_score);
          foreach (nd_rec.crn[k, e]) nd_rec.crn[k][e] = 0;
          dets = {dets, nd_rec};
          latest_ok = 1;
        end
      end
      KIND_CORNER: begin
        if (latest_ok && dets.size() > 0) begin
          dets[$].crn[it.corner_index][0] = int'(it.corner_x);
          dets[$].crn[it.corner_index][1] = int'(it.corner_y);
        end
      end
      KIND_END: track_frame();
      default: ;
    endcase
  endtask

  // driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (det_valid && det_ready) begin
        predict_item(det_item);
        void'(pending_items.pop_front());
      end
      if (det_valid && !det_ready) begin
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        det_valid <= 0;
      end else if (det_valid && det_ready && $urandom_range(0, 3) == 0) begin
        det_valid <= 0;
        send_gap <= $urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(0, 3);
      end else if (pending_items.size() > 0 && !drain_req) begin
        det_valid <= 1;
        det_item <= pending_items[0];
      end else begin
        det_valid <= 0;
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    if (!rst) begin
      if (trk_valid && trk_ready) begin
        if (expected_tracks.size() == 0) begin
          report($sformatf("unexpected item id %0d", trk_item.track_id));
        end else if (trk_item !== expected_tracks[0]) begin
          report($sformatf("got %h want %h", trk_item, expected_tracks[0]));
          void'(expected_tracks.pop_front());
        end else begin
          void'(expected_tracks.pop_front());
        end
      end
      if (hold_off && !hold_done) begin
        trk_ready <= 0;
        hold_left <= HOLD_LONG;
        hold_done <= 1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        trk_ready <= 0;
      end else if ($urandom_range(0, 5) == 0) begin
        trk_ready <= 0;
        hold_left <= $urandom_range(0, 12) == 0 ? $urandom_range(10, 60) : $urandom_range(0, 2);
      end else begin
        trk_ready <= 1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((det_valid && det_ready) || (trk_valid && trk_ready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic apb_write(logic [1:0] idx, int val);
    @(posedge clk);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= PADDR_W'(4 * idx);
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      REG_IOU: thr_q8 = val & 9'h1ff;
      REG_ALPHA: alpha_q8 = val & 9'h1ff;
      default: miss_lim = val & 8'hff;
    endcase
  endtask

  task automatic wait_quiet();
    while (pending_items.size() > 0 || det_valid) @(posedge clk);
    while (expected_tracks.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic det_item_t box_item(int x, int y, int w, int h, int s);
    det_item_t it = '0;
    it.kind = KIND_BOX;
    it.box_x = x[15:0];
    it.box_y = y[15:0];
    it.box_w = w[14:0];
    it.box_h = h[14:0];
    it.det_score = s[15:0];
    return it;
  endfunction

  function automatic det_item_t corner_item(int c, int x, int y);
    det_item_t it = '0;
    it.kind = KIND_CORNER;
    it.corner_index = c[1:0];
    it.corner_x = x[15:0];
    it.corner_y = y[15:0];
    return it;
  endfunction

  function automatic det_item_t end_item();
    det_item_t it = '0;
    it.kind = KIND_END;
    return it;
  endfunction

  // random frame around existing tracks so that matches happen often
  task automatic queue_frame(int ndet);
    int bx, by;
    for (int j = 0; j < ndet; j++) begin
      if (tracks.size() > 0 && $urandom_range(0, 3) != 0) begin
        bx = tracks[$urandom_range(0, tracks.size() - 1)].box[0] + $urandom_range(0, 40) - 20;
        by = tracks[$urandom_range(0, tracks.size() - 1)].box[1] + $urandom_range(0, 40) - 20;
      end else begin
        bx = $urandom_range(0, 3000) - 1500;
        by = $urandom_range(0, 3000) - 1500;
      end
      if ($urandom_range(0, 15) == 0) begin
        bx = $urandom_range(0, 1) ? 32767 : -32768;
        by = $urandom_range(0, 1) ? 32767 : -32768;
      end
      enqueue_in(box_item(bx, by, $urandom_range(0, 15) == 0 ? $urandom_range(0, 32767)
                          : $urandom_range(50, 400), $urandom_range(0, 15) == 0 ?
                          $urandom_range(0, 32767) : $urandom_range(50, 400),
                          $urandom_range(0, 65535)));
      for (int k = 0; k < 4; k++)
        if ($urandom_range(0, 4) != 0)
          enqueue_in(corner_item($urandom_range(0, 3), $urandom_range(0, 65535),
                                 $urandom_range(0, 65535)));
      if ($urandom_range(0, 20) == 0) begin
        det_item_t junk;
        logic [127:0] raw_bits;
        raw_bits = {$urandom, $urandom, $urandom, $urandom};
        junk = det_item_t'(raw_bits[$bits(det_item_t)-1:0]);
        junk.kind = 2'd3;
        enqueue_in(junk);
      end
    end
    enqueue_in(end_item());
  endtask

  initial begin
    ident_next = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    // directed part
    enqueue_in(end_item());
    enqueue_in(corner_item(1, 5, 5));
    enqueue_in(box_item(-32768, -32768, 32767, 32767, 65535));
    enqueue_in(corner_item(0, -32768, 32767));
    enqueue_in(corner_item(3, 32767, -32768));
    enqueue_in(box_item(32767, 32767, 0, 0, 0));
    enqueue_in(box_item(100, 100, 200, 200, 1234));
    enqueue_in(end_item());
    enqueue_in(box_item(110, 90, 200, 210, 4321));
    enqueue_in(corner_item(2, -7, 9));
    enqueue_in(box_item(100, 100, 200, 200, 999));
    enqueue_in(end_item());
    wait_quiet();
    // full detection store, overflow drops, track store full
    for (int r = 0; r < 2; r++) begin
      for (int j = 0; j < NDET + 2; j++)
        enqueue_in(box_item(j * 1000 - 9000 + r * 7, r * 5000, 300, 300, j));
      enqueue_in(corner_item(0, 1, 1));
      enqueue_in(end_item());
    end
    // receiver holds off while the sender keeps offering items
    hold_off = 1;
    queue_frame(3);
    queue_frame(2);
    wait_quiet();
    apb_write(REG_IOU, 0);
    apb_write(REG_ALPHA, 256);
    apb_write(REG_MISSED, 0);
    for (int f = 0; f < 4; f++) queue_frame($urandom_range(0, 4));
    wait_quiet();
    apb_write(REG_IOU, 256);
    apb_write(REG_ALPHA, 0);
    apb_write(REG_MISSED, 255);
    for (int f = 0; f < 3; f++) queue_frame($urandom_range(1, 3));
    wait_quiet();
    apb_write(REG_IOU, 511);
    apb_write(REG_ALPHA, 511);
    apb_write(REG_MISSED, 1);
    queue_frame(3);
    queue_frame(2);
    wait_quiet();
    // random settings and frames
    for (int p = 0; p < 4; p++) begin
      apb_write(REG_IOU, $urandom_range(0, 200));
      apb_write(REG_ALPHA, $urandom_range(0, 300));
      apb_write(REG_MISSED, $urandom_range(0, 6));
      for (int f = 0; f < 2; f++) queue_frame($urandom_range(0, 6));
      while (pending_items.size() > 0) @(posedge clk);
      if (p == 1) begin
        drain_req = 1;
        while (det_valid || expected_tracks.size() > 0) @(posedge clk);
        drain_req = 0;
      end
      wait_quiet();
    end
    if (errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end
endmodule
